@@ rtl/hhe_pkg.sv @@
// ----------------------------------------------------------------------------
// Height estimate package
// Shared formats, widths and register indexes of the height estimator.
// ----------------------------------------------------------------------------
package hhe_pkg;

  // Fixed-point formats.
  localparam int unsigned CoefFracBits  = 16;  // Q16.16 coefficients and results
  localparam int unsigned PixelFracBits = 4;   // Q12.4 pixel coordinates
  localparam int unsigned HpShift       = 24;  // extra precision of the pixel height

  // Datapath widths.
  localparam int unsigned PixW    = 16;                      // pixel coordinate
  localparam int unsigned SqW     = 2 * PixW + 1;            // dx^2 + dy^2
  localparam int unsigned ProdW   = 48;                      // coefficient times pixel
  localparam int unsigned SumW    = 50;                      // homography sum, signed
  localparam int unsigned MagW    = SumW - 1;                // magnitude of a sum
  localparam int unsigned MapQW   = 41;                      // mapped magnitude bits
  localparam int unsigned MapNumW = MagW + CoefFracBits;     // dividend of the mapping
  localparam int unsigned MapW    = MapQW + 1;               // mapped point, signed
  localparam int unsigned ErrW    = MapW + 1;                // mapped minus camera
  localparam int unsigned OutW    = 32;                      // result fields
  localparam int unsigned RootInW = 2 * OutW;                // square root operand

  // Largest magnitude of a mapped coordinate (2^40 in raw units).
  localparam logic [MapQW-1:0] MapLimit = MapQW'(1) << (MapQW - 1);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [31:0] H22Reset = 32'h0001_0000;  // 1.0

  typedef enum logic [CfgIdxW-1:0] {
    CfgHomRow0Ab    = 3'd0,
    CfgHomRow0cRow1a = 3'd1,
    CfgHomRow1Bc    = 3'd2,
    CfgHomRow2Ab    = 3'd3,
    CfgHomRow2C     = 3'd4,
    CfgCameraPos    = 3'd5,
    CfgFocalY       = 3'd6,
    CfgEnabled      = 3'd7
  } cfg_idx_e;

endpackage

@@ rtl/homography_height_estimate.sv @@
// ----------------------------------------------------------------------------
// Homography height estimate
// Pixel height from a head and a foot point, ground distance of the foot point
// mapped through a ground homography, and the real height derived from both.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one detection per beat: head_x, head_y, foot_x and
// foot_y, signed Q12.4. The master stream gives one beat per detection:
// the real height and ground_distance (unsigned Q16.16) in tdata, valid_res in
// tuser. Results come back in order, one for each detection.
// Calibration goes in through the write port while no detection is in flight.
// Throughput is one beat per cycle while the receiver does not stall. The two
// 41-step mapping divisions, the 32-step height division and the 32-step
// square roots each work out one bit per stage.
// Reset clears all valid bits and loads the calibration defaults (h22 = 1.0,
// everything else zero, block disabled). When the receiver stalls, the output
// register holds its beat; the pipeline keeps moving as long as its last
// stage is empty, and freezes as a whole otherwise, so nothing is dropped.
// ----------------------------------------------------------------------------
module homography_height_estimate
  import hhe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Detection stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // head_x, head_y, foot_x, foot_y
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // real height, ground_distance
  output logic [0:0]          m_axis_tuser    // valid_res
);

  // --------------------------------------------------------------------------
  // Calibration registers.
  // --------------------------------------------------------------------------
  logic [63:0] hom0_q, hom1_q, hom2_q, hom3_q, cam_q;
  logic [31:0] h22_q, focal_q;
  logic        enabled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hom0_q    <= '0;
      hom1_q    <= '0;
      hom2_q    <= '0;
      hom3_q    <= '0;
      h22_q     <= H22Reset;
      cam_q     <= '0;
      focal_q   <= '0;
      enabled_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgHomRow0Ab:     hom0_q    <= cfg_data_i;
        CfgHomRow0cRow1a: hom1_q    <= cfg_data_i;
        CfgHomRow1Bc:     hom2_q    <= cfg_data_i;
        CfgHomRow2Ab:     hom3_q    <= cfg_data_i;
        CfgHomRow2C:      h22_q     <= cfg_data_i[31:0];
        CfgCameraPos:     cam_q     <= cfg_data_i;
        CfgFocalY:        focal_q   <= cfg_data_i[31:0];
        CfgEnabled:       enabled_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22, cam_x, cam_y;
  assign h00   = hom0_q[63:32];
  assign h01   = hom0_q[31:0];
  assign h02   = hom1_q[63:32];
  assign h10   = hom1_q[31:0];
  assign h11   = hom2_q[63:32];
  assign h12   = hom2_q[31:0];
  assign h20   = hom3_q[63:32];
  assign h21   = hom3_q[31:0];
  assign h22   = h22_q;
  assign cam_x = cam_q[63:32];
  assign cam_y = cam_q[31:0];

  // --------------------------------------------------------------------------
  // Pipeline advance: the whole pipeline freezes only when its last stage
  // holds a result and the output register cannot take it.
  // --------------------------------------------------------------------------
  logic en;
  logic hdiv_v;
  logic out_v_q;

  assign en            = !(hdiv_v && out_v_q && !m_axis_tready);
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: input register.
  // --------------------------------------------------------------------------
  logic                   v1_q;
  logic signed [PixW-1:0] hx1_q, hy1_q, fx1_q, fy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hx1_q <= s_axis_tdata[15:0];
      hy1_q <= s_axis_tdata[31:16];
      fx1_q <= s_axis_tdata[47:32];
      fy1_q <= s_axis_tdata[63:48];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: point differences and homography products.
  // --------------------------------------------------------------------------
  logic signed [PixW:0]    dx, dy;
  logic [PixW-1:0]         dxm_d, dym_d;
  logic signed [ProdW-1:0] p00_d, p01_d, p10_d, p11_d, p20_d, p21_d;

  assign dx    = (PixW + 1)'(hx1_q) - (PixW + 1)'(fx1_q);
  assign dy    = (PixW + 1)'(hy1_q) - (PixW + 1)'(fy1_q);
  assign dxm_d = dx[PixW] ? PixW'(-dx) : PixW'(dx);
  assign dym_d = dy[PixW] ? PixW'(-dy) : PixW'(dy);
  assign p00_d = ProdW'(h00) * ProdW'(fx1_q);
  assign p01_d = ProdW'(h01) * ProdW'(fy1_q);
  assign p10_d = ProdW'(h10) * ProdW'(fx1_q);
  assign p11_d = ProdW'(h11) * ProdW'(fy1_q);
  assign p20_d = ProdW'(h20) * ProdW'(fx1_q);
  assign p21_d = ProdW'(h21) * ProdW'(fy1_q);

  logic                    v2_q;
  logic [PixW-1:0]         dxm2_q, dym2_q;
  logic signed [ProdW-1:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxm2_q <= dxm_d;
      dym2_q <= dym_d;
      p00_q  <= p00_d;
      p01_q  <= p01_d;
      p10_q  <= p10_d;
      p11_q  <= p11_d;
      p20_q  <= p20_d;
      p21_q  <= p21_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squared differences and homography sums.
  // --------------------------------------------------------------------------
  logic                   v3_q;
  logic [2*PixW-1:0]      dx2_q, dy2_q;
  logic signed [SumW-1:0] nx3_q, ny3_q, w3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx2_q <= (2 * PixW)'(dxm2_q) * (2 * PixW)'(dxm2_q);
      dy2_q <= (2 * PixW)'(dym2_q) * (2 * PixW)'(dym2_q);
      nx3_q <= SumW'(p00_q) + SumW'(p01_q) + (SumW'(h02) <<< PixelFracBits);
      ny3_q <= SumW'(p10_q) + SumW'(p11_q) + (SumW'(h12) <<< PixelFracBits);
      w3_q  <= SumW'(p20_q) + SumW'(p21_q) + (SumW'(h22) <<< PixelFracBits);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum of squares, magnitudes and signs of the mapping.
  // --------------------------------------------------------------------------
  logic            v4_q;
  logic [SqW-1:0]  s4_q;
  logic [MagW-1:0] nxm4_q, nym4_q, wm4_q;
  logic            negx4_q, negy4_q, wz4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q    <= SqW'(dx2_q) + SqW'(dy2_q);
      nxm4_q  <= nx3_q[SumW-1] ? MagW'(-nx3_q) : MagW'(nx3_q);
      nym4_q  <= ny3_q[SumW-1] ? MagW'(-ny3_q) : MagW'(ny3_q);
      wm4_q   <= w3_q[SumW-1] ? MagW'(-w3_q) : MagW'(w3_q);
      negx4_q <= nx3_q[SumW-1] ^ w3_q[SumW-1];
      negy4_q <= ny3_q[SumW-1] ^ w3_q[SumW-1];
      wz4_q   <= (w3_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Mapping division: |n| * 2^16 / |w| for both ground coordinates.
  // --------------------------------------------------------------------------
  localparam int unsigned MapTagW = SqW + 2;

  logic               mapx_v, mapy_v, mapx_ovf, mapy_ovf;
  logic [MapQW-1:0]   mapx_q, mapy_q;
  logic [MapTagW-1:0] mapx_tag;
  logic               mapy_neg;

  hhe_div #(
    .NUM_W(MapNumW),
    .DEN_W(MagW),
    .Q_W  (MapQW),
    .TAG_W(MapTagW)
  ) u_div_mapx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v4_q),
    .num_i  ({nxm4_q, CoefFracBits'(0)}),
    .den_i  (wm4_q),
    .tag_i  ({s4_q, negx4_q, wz4_q}),
    .valid_o(mapx_v),
    .quo_o  (mapx_q),
    .ovf_o  (mapx_ovf),
    .tag_o  (mapx_tag)
  );

  hhe_div #(
    .NUM_W(MapNumW),
    .DEN_W(MagW),
    .Q_W  (MapQW),
    .TAG_W(1)
  ) u_div_mapy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v4_q),
    .num_i  ({nym4_q, CoefFracBits'(0)}),
    .den_i  (wm4_q),
    .tag_i  (negy4_q),
    .valid_o(mapy_v),
    .quo_o  (mapy_q),
    .ovf_o  (mapy_ovf),
    .tag_o  (mapy_neg)
  );

  // --------------------------------------------------------------------------
  // Stage E1: saturate and sign the mapped point; zero w maps to the origin.
  // --------------------------------------------------------------------------
  logic [SqW-1:0]         s_map;
  logic                   negx_map, wz_map;
  logic [MapQW-1:0]       magx, magy;
  logic signed [MapW-1:0] mxu, myu;

  assign {s_map, negx_map, wz_map} = mapx_tag;
  assign magx = (mapx_ovf || (mapx_q[MapQW-1] && |mapx_q[MapQW-2:0])) ? MapLimit : mapx_q;
  assign magy = (mapy_ovf || (mapy_q[MapQW-1] && |mapy_q[MapQW-2:0])) ? MapLimit : mapy_q;
  assign mxu  = {1'b0, magx};
  assign myu  = {1'b0, magy};

  logic                   e1_v_q;
  logic [SqW-1:0]         e1_s_q;
  logic signed [MapW-1:0] e1_mx_q, e1_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
    end else if (en) begin
      e1_v_q <= mapx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_s_q  <= s_map;
      e1_mx_q <= wz_map ? '0 : (negx_map ? -mxu : mxu);
      e1_my_q <= wz_map ? '0 : (mapy_neg ? -myu : myu);
    end
  end

  // --------------------------------------------------------------------------
  // Stage E2: offset from the camera ground position.
  // --------------------------------------------------------------------------
  logic                   e2_v_q;
  logic [SqW-1:0]         e2_s_q;
  logic signed [ErrW-1:0] e2_ex_q, e2_ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_v_q <= 1'b0;
    end else if (en) begin
      e2_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_s_q  <= e1_s_q;
      e2_ex_q <= ErrW'(e1_mx_q) - ErrW'(cam_x);
      e2_ey_q <= ErrW'(e1_my_q) - ErrW'(cam_y);
    end
  end

  // --------------------------------------------------------------------------
  // Stage E3: offset magnitudes; anything at or above 2^32 saturates.
  // --------------------------------------------------------------------------
  logic [ErrW-1:0] uxf, uyf;
  assign uxf = e2_ex_q[ErrW-1] ? ErrW'(-e2_ex_q) : ErrW'(e2_ex_q);
  assign uyf = e2_ey_q[ErrW-1] ? ErrW'(-e2_ey_q) : ErrW'(e2_ey_q);

  logic            e3_v_q;
  logic [SqW-1:0]  e3_s_q;
  logic [OutW-1:0] e3_ux_q, e3_uy_q;
  logic            e3_big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_v_q <= 1'b0;
    end else if (en) begin
      e3_v_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_s_q   <= e2_s_q;
      e3_ux_q  <= uxf[OutW-1:0];
      e3_uy_q  <= uyf[OutW-1:0];
      e3_big_q <= (|uxf[ErrW-1:OutW]) || (|uyf[ErrW-1:OutW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage E4: squared offsets.
  // --------------------------------------------------------------------------
  logic               e4_v_q;
  logic [SqW-1:0]     e4_s_q;
  logic [2*OutW-1:0]  e4_sqx_q, e4_sqy_q;
  logic               e4_big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e4_v_q <= 1'b0;
    end else if (en) begin
      e4_v_q <= e3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e4_s_q   <= e3_s_q;
      e4_sqx_q <= (2 * OutW)'(e3_ux_q) * (2 * OutW)'(e3_ux_q);
      e4_sqy_q <= (2 * OutW)'(e3_uy_q) * (2 * OutW)'(e3_uy_q);
      e4_big_q <= e3_big_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E5: squared distance; a carry out of 64 bits saturates.
  // --------------------------------------------------------------------------
  logic [RootInW:0] sq_sum;
  assign sq_sum = (RootInW + 1)'(e4_sqx_q) + (RootInW + 1)'(e4_sqy_q);

  logic               e5_v_q;
  logic [SqW-1:0]     e5_s_q;
  logic [RootInW-1:0] e5_sq_q;
  logic               e5_sqbig_q, e5_ubig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e5_v_q <= 1'b0;
    end else if (en) begin
      e5_v_q <= e4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e5_s_q     <= e4_s_q;
      e5_sq_q    <= sq_sum[RootInW-1:0];
      e5_sqbig_q <= sq_sum[RootInW];
      e5_ubig_q  <= e4_big_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square roots: ground distance and pixel height side by side.
  // --------------------------------------------------------------------------
  logic            dist_v, hp_v, dist_sqbig, hp_ubig;
  logic [OutW-1:0] dist_root, hp_root;

  hhe_sqrt #(
    .W    (RootInW),
    .TAG_W(1)
  ) u_sqrt_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(e5_v_q),
    .val_i  (e5_sq_q),
    .tag_i  (e5_sqbig_q),
    .valid_o(dist_v),
    .root_o (dist_root),
    .tag_o  (dist_sqbig)
  );

  hhe_sqrt #(
    .W    (RootInW),
    .TAG_W(1)
  ) u_sqrt_hp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(e5_v_q),
    .val_i  (RootInW'({e5_s_q, HpShift'(0)})),
    .tag_i  (e5_ubig_q),
    .valid_o(hp_v),
    .root_o (hp_root),
    .tag_o  (hp_ubig)
  );

  // --------------------------------------------------------------------------
  // Stage H1: pixel height times ground distance.
  // --------------------------------------------------------------------------
  logic [OutW-1:0] dist_sat;
  assign dist_sat = (dist_sqbig || hp_ubig) ? '1 : dist_root;

  logic               h1_v_q;
  logic [OutW-1:0]    h1_dist_q;
  logic [2*OutW-1:0]  h1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
    end else if (en) begin
      h1_v_q <= dist_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_dist_q <= dist_sat;
      h1_prod_q <= (2 * OutW)'(hp_root) * (2 * OutW)'(dist_sat);
    end
  end

  // --------------------------------------------------------------------------
  // Height division by the focal length; the format shifts cancel.
  // --------------------------------------------------------------------------
  logic            hdiv_ovf;
  logic [OutW-1:0] hdiv_q, hdiv_dist;

  hhe_div #(
    .NUM_W(2 * OutW),
    .DEN_W(OutW),
    .Q_W  (OutW),
    .TAG_W(OutW)
  ) u_div_height (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(h1_v_q),
    .num_i  (h1_prod_q),
    .den_i  (focal_q),
    .tag_i  (h1_dist_q),
    .valid_o(hdiv_v),
    .quo_o  (hdiv_q),
    .ovf_o  (hdiv_ovf),
    .tag_o  (hdiv_dist)
  );

  // --------------------------------------------------------------------------
  // Output register; a disabled block or a zero focal length gives zeros.
  // --------------------------------------------------------------------------
  logic            active;
  logic [OutW-1:0] out_height_q, out_dist_q;
  logic            out_res_q;

  assign active = enabled_q && (focal_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= hdiv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_height_q <= active ? (hdiv_ovf ? '1 : hdiv_q) : '0;
      out_dist_q   <= active ? hdiv_dist : '0;
      out_res_q    <= active;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_dist_q, out_height_q};
  assign m_axis_tuser  = out_res_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The input side only stalls behind a result that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

  // Both mapping dividers carry the same items.
  a_map_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mapx_v == mapy_v)
    else $error("mapping dividers out of step");

  // Both square roots carry the same items.
  a_root_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_v == hp_v)
    else $error("square roots out of step");

  // A result that is not computed carries zeros.
  a_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("uncomputed result is not zero");

endmodule

@@ rtl/hhe_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces floor(num / den) one quotient bit per stage, with an overflow flag
// when the quotient does not fit. A tag travels alongside each operand pair.
// ----------------------------------------------------------------------------
module hhe_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 32,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic             ovf_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned HiW  = NUM_W - Q_W;
  localparam int unsigned CmpW = (HiW > DEN_W) ? HiW : DEN_W;

  logic             vld_q [Q_W+1];
  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   lo_q  [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [TAG_W-1:0] tag_q [Q_W+1];
  logic             ovf_q [Q_W+1];

  // The quotient overflows when the high part of the dividend reaches den.
  logic ovf_in;
  assign ovf_in = CmpW'(num_i[NUM_W-1:Q_W]) >= CmpW'(den_i);

  // Entry stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // Entry stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_W'(num_i[NUM_W-1:Q_W]);
      lo_q[0]  <= num_i[Q_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      ovf_q[0] <= ovf_in;
    end
  end

  // One quotient bit per stage.
  for (genvar g = 0; g < Q_W; g++) begin : g_step
    logic [DEN_W:0] trial;
    logic           take;

    assign trial = {rem_q[g], lo_q[g][Q_W-1]};
    assign take  = trial >= {1'b0, den_q[g]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1] <= take ? DEN_W'(trial - {1'b0, den_q[g]}) : DEN_W'(trial);
        lo_q[g+1]  <= lo_q[g] << 1;
        quo_q[g+1] <= (quo_q[g] << 1) | Q_W'(take);
        den_q[g+1] <= den_q[g];
        tag_q[g+1] <= tag_q[g];
        ovf_q[g+1] <= ovf_q[g];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = quo_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign tag_o   = tag_q[Q_W];

endmodule

@@ rtl/hhe_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Produces floor(sqrt(x)) one root bit per stage from two operand bits at a
// time. A tag travels alongside each operand.
// ----------------------------------------------------------------------------
module hhe_sqrt #(
  parameter int unsigned W     = 64,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [W-1:0]     val_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [W/2-1:0]   root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned HalfW = W / 2;
  localparam int unsigned RemW  = HalfW + 2;

  logic             vld_q  [HalfW+1];
  logic [W-1:0]     val_q  [HalfW+1];
  logic [HalfW-1:0] root_q [HalfW+1];
  logic [RemW-1:0]  rem_q  [HalfW+1];
  logic [TAG_W-1:0] tag_q  [HalfW+1];

  // Entry stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // Entry stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q[0]  <= val_i;
      root_q[0] <= '0;
      rem_q[0]  <= '0;
      tag_q[0]  <= tag_i;
    end
  end

  // Each stage brings down two operand bits and decides one root bit.
  for (genvar g = 0; g < HalfW; g++) begin : g_step
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    logic            take;

    assign cur   = {rem_q[g], val_q[g][W-1:W-2]};
    assign trial = (RemW + 2)'({root_q[g], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= take ? RemW'(cur - trial) : RemW'(cur);
        root_q[g+1] <= (root_q[g] << 1) | HalfW'(take);
        val_q[g+1]  <= val_q[g] << 2;
        tag_q[g+1]  <= tag_q[g];
      end
    end
  end

  assign valid_o = vld_q[HalfW];
  assign root_o  = root_q[HalfW];
  assign tag_o   = tag_q[HalfW];

endmodule
